### hdl/loss_value_accumulator_assert.svh
// Assertion macros for the loss value accumulator.
// Each macro expects clk and rst to be in scope.
`ifndef LOSS_VALUE_ACCUMULATOR_ASSERT_SVH
`define LOSS_VALUE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define LVA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lva check failed");

// next-cycle implication
`define LVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lva check failed");

`endif

### hdl/lva_pkg.sv
// Shared types, constants and the log2 fraction table of the loss accumulator.
// No dependencies.
package lva_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = FRAC_BITS + 1;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SUM_W       = 48;
  localparam int CNT_W       = 16;
  localparam int NLOG_W      = 21;
  localparam int TERM_W      = 22;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

  // loss modes
  localparam logic [1:0] MODE_CE   = 2'd0;
  localparam logic [1:0] MODE_NLL  = 2'd1;
  localparam logic [1:0] MODE_QUAD = 2'd2;

  // register byte addresses
  localparam logic [1:0] ADDR_LOSS_MODE = 2'd0;

  typedef enum logic [1:0] {OP_CE, OP_NLL, OP_QUAD, OP_NONE} op_t;

  typedef enum logic [2:0] {BS_IDLE, BS_LOG, BS_LN, BS_WGT, BS_ACC} back_state_t;

  // one classified word between front and back
  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] e;
    logic [VAL_W-1:0] a;
    logic             last;
  } work_t;

  typedef logic [15:0] log_table_t [TABLE_DEPTH];

  // log2(1 + i/D) in Q16 by repeated squaring in Q2.30
  function automatic log_table_t build_log_table();
    log_table_t       t;
    longint unsigned  y;
    logic [15:0]      r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      y = ((longint'(TABLE_DEPTH + i)) << 30) / TABLE_DEPTH;
      r = '0;
      for (int k = 1; k <= 16; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          r[16-k] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam log_table_t LOG_TABLE = build_log_table();

endpackage

### hdl/loss_value_accumulator.sv
// Loss value accumulator.
// Input queue: push/full carry (expected_value, actual_value, last_element)
// words, probabilities in Q16 where 65536 is 1.0. Result queue: empty/pop
// carry (loss_value, element_count, saturated), one result per word marked
// last. loss_mode (APB address 0) picks cross entropy, NLL or quadratic loss.
// A front end clamps and classifies words into a 2-entry queue; a back end
// runs one shared log unit and accumulates with saturation.
// Cross entropy makes two log passes, each of leading-one/table, ln2 multiply,
// weight multiply and accumulate; NLL makes one; quadratic and the unused
// mode go from the log step straight to accumulate. The back end takes a new
// word only once it is through with the last; its single log unit sets this.
// Reset empties both queues, clears the sum, count and flag, mode to 0.
// When the receiver does not pop, a finished result holds; the back end
// stops only at the next last word, and the input queue fills, raising full.
// Config writes are meant for idle periods.
// Depends on lva_pkg, lva_front, lva_back, loss_value_accumulator_assert.svh.
`include "loss_value_accumulator_assert.svh"
module loss_value_accumulator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic [lva_pkg::VAL_W-1:0]   expected_value,
  input  logic [lva_pkg::VAL_W-1:0]   actual_value,
  input  logic                        last_element,
  output logic                        empty,
  input  logic                        pop,
  output logic [lva_pkg::SUM_W-1:0]   loss_value,
  output logic [lva_pkg::CNT_W-1:0]   element_count,
  output logic                        saturated
);

  logic [1:0]     loss_mode;
  logic           q_valid, q_take;
  lva_pkg::work_t q_word;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == lva_pkg::ADDR_LOSS_MODE) ? {30'd0, loss_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) loss_mode <= lva_pkg::MODE_CE;
    else if (psel && penable && pwrite && paddr == lva_pkg::ADDR_LOSS_MODE)
      loss_mode <= pwdata[1:0];
  end

  lva_front u_front (
    .clk, .rst, .push, .full, .expected_value, .actual_value, .last_element,
    .mode(loss_mode), .q_valid, .q_take, .q_word
  );

  lva_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_word, .empty, .pop,
    .loss_value, .element_count, .saturated
  );

  // checks
  `LVA_ASSERT_IMPL(a_sat_max, !empty && saturated, loss_value == '1)
  `LVA_ASSERT_IMPL(a_count_nz, !empty, element_count != '0)
  `LVA_ASSERT_NEXT(a_rst_empty, $past(rst), empty && !full)

endmodule

### hdl/lva_front.sv
// Front end: clamps and classifies input words, buffers them in a 2-entry queue.
// Depends on lva_pkg.
module lva_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [lva_pkg::VAL_W-1:0]   expected_value,
  input  logic [lva_pkg::VAL_W-1:0]   actual_value,
  input  logic                        last_element,
  input  logic [1:0]                  mode,
  output logic                        q_valid,
  input  logic                        q_take,
  output lva_pkg::work_t              q_word
);

  lva_pkg::work_t        word_in;
  lva_pkg::work_t        slots [2];
  logic [lva_pkg::VAL_W-1:0] e_cl, a_cl;
  logic                  wr_ptr, rd_ptr;
  logic [1:0]            count;
  logic                  do_push, do_pop;

  // clamp to 1.0, pick the operation and keep log operands off 0 (and off 1.0 for CE)
  always_comb begin
    e_cl = (expected_value > lva_pkg::ONE_VAL) ? lva_pkg::ONE_VAL : expected_value;
    a_cl = (actual_value > lva_pkg::ONE_VAL) ? lva_pkg::ONE_VAL : actual_value;
    word_in.e    = e_cl;
    word_in.a    = a_cl;
    word_in.last = last_element;
    unique case (mode)
      lva_pkg::MODE_CE: begin
        word_in.op = lva_pkg::OP_CE;
        if (a_cl == '0) word_in.a = lva_pkg::VAL_W'(1);
        else if (a_cl == lva_pkg::ONE_VAL) word_in.a = lva_pkg::ONE_VAL - lva_pkg::VAL_W'(1);
      end
      lva_pkg::MODE_NLL: begin
        word_in.op = lva_pkg::OP_NLL;
        if (a_cl == '0) word_in.a = lva_pkg::VAL_W'(1);
      end
      lva_pkg::MODE_QUAD: word_in.op = lva_pkg::OP_QUAD;
      default:            word_in.op = lva_pkg::OP_NONE;
    endcase
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_word  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= word_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### hdl/lva_back.sv
// Back end: log unit sequencer, weighting, saturating accumulator, result register.
// Depends on lva_pkg.
module lva_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_take,
  input  lva_pkg::work_t                q_word,
  output logic                          empty,
  input  logic                          pop,
  output logic [lva_pkg::SUM_W-1:0]     loss_value,
  output logic [lva_pkg::CNT_W-1:0]     element_count,
  output logic                          saturated
);

  lva_pkg::back_state_t state, state_next;
  lva_pkg::work_t       cur;
  logic                 pass;
  logic [lva_pkg::NLOG_W-1:0] nlog2;
  logic [lva_pkg::NLOG_W-1:0] nl;
  logic [lva_pkg::TERM_W-1:0] term;
  logic [lva_pkg::SUM_W-1:0]  loss_sum;
  logic [lva_pkg::CNT_W-1:0]  seen;
  logic                 ovf;
  logic                 out_valid;
  logic                 acc_fire, final_part;

  // log operand for this pass
  logic [lva_pkg::VAL_W-1:0] x, w;
  logic [3:0]                 p;
  logic [15:0]                norm;
  logic [lva_pkg::IDX_W-1:0] idx;
  logic [lva_pkg::NLOG_W-1:0] nlog2_c;
  logic [lva_pkg::VAL_W-1:0] d;
  logic [2*lva_pkg::VAL_W-1:0] sq;
  logic [lva_pkg::NLOG_W+31:0] ln_prod;
  logic [lva_pkg::VAL_W+lva_pkg::NLOG_W-1:0] w_prod;
  logic [lva_pkg::SUM_W:0]    sum_ext;
  logic [lva_pkg::CNT_W-1:0]  seen_inc;

  always_comb begin
    x = pass ? (lva_pkg::ONE_VAL - cur.a) : cur.a;
    w = pass ? (lva_pkg::ONE_VAL - cur.e) : cur.e;
  end

  // leading-one position of the low 16 bits, table lookup and -log2 of x in Q16
  always_comb begin
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) p = 4'(i);
    end
    norm = x[15:0] << (4'd15 - p);
    idx  = norm[14:15-lva_pkg::IDX_W];
    if (x[16]) nlog2_c = '0;
    else nlog2_c = (lva_pkg::NLOG_W'(5'd16 - {1'b0, p}) << 16)
                   - lva_pkg::NLOG_W'(lva_pkg::LOG_TABLE[idx]);
  end

  // quadratic term
  always_comb begin
    d  = (cur.e >= cur.a) ? cur.e - cur.a : cur.a - cur.e;
    sq = d * d;
  end

  assign ln_prod  = nlog2 * lva_pkg::LN2_Q32 + (lva_pkg::NLOG_W+32)'(64'd1 << 31);
  assign w_prod   = w * nl;
  assign sum_ext  = {1'b0, loss_sum} + (lva_pkg::SUM_W+1)'(term);
  assign seen_inc = (seen == '1) ? seen : seen + 1'b1;

  assign final_part = (cur.op != lva_pkg::OP_CE) || pass;
  assign empty      = !out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lva_pkg::BS_IDLE: if (q_valid) state_next = lva_pkg::BS_LOG;
      lva_pkg::BS_LOG: begin
        if (cur.op == lva_pkg::OP_CE || cur.op == lva_pkg::OP_NLL)
          state_next = lva_pkg::BS_LN;
        else state_next = lva_pkg::BS_ACC;
      end
      lva_pkg::BS_LN:  state_next = lva_pkg::BS_WGT;
      lva_pkg::BS_WGT: state_next = lva_pkg::BS_ACC;
      lva_pkg::BS_ACC: begin
        if (acc_fire) state_next = final_part ? lva_pkg::BS_IDLE : lva_pkg::BS_LOG;
      end
      default: state_next = lva_pkg::BS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_take   = (state == lva_pkg::BS_IDLE);
    acc_fire = (state == lva_pkg::BS_ACC) &&
               !(final_part && cur.last && out_valid && !pop);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lva_pkg::BS_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == lva_pkg::BS_IDLE && q_valid) cur <= q_word;
    if (state == lva_pkg::BS_LOG) begin
      nlog2 <= nlog2_c;
      if (cur.op == lva_pkg::OP_QUAD)
        term <= lva_pkg::TERM_W'(sq >> (lva_pkg::FRAC_BITS + 1));
      else term <= '0;
    end
    if (state == lva_pkg::BS_LN) nl <= lva_pkg::NLOG_W'(ln_prod >> 32);
    if (state == lva_pkg::BS_WGT) term <= lva_pkg::TERM_W'(w_prod >> lva_pkg::FRAC_BITS);
  end

  // pass, accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pass      <= 1'b0;
      loss_sum  <= '0;
      seen      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc_fire && final_part && cur.last) out_valid <= 1'b1;
      else if (pop && out_valid)              out_valid <= 1'b0;
      if (acc_fire) begin
        pass <= !final_part;
        if (final_part && cur.last) begin
          loss_value    <= sum_ext[lva_pkg::SUM_W] ? '1 : sum_ext[lva_pkg::SUM_W-1:0];
          saturated     <= ovf || sum_ext[lva_pkg::SUM_W];
          element_count <= seen_inc;
          loss_sum      <= '0;
          seen          <= '0;
          ovf           <= 1'b0;
        end else begin
          if (sum_ext[lva_pkg::SUM_W]) begin
            loss_sum <= '1;
            ovf      <= 1'b1;
          end else begin
            loss_sum <= sum_ext[lva_pkg::SUM_W-1:0];
          end
          if (final_part) seen <= seen_inc;
        end
      end
    end
  end

endmodule
